[src/uyvy_pkg.sv]
// Package: register indexes, reset values and conversion coefficients.
`default_nettype none

package uyvy_pkg;

  typedef logic [1:0] cfg_idx_t;

  localparam cfg_idx_t CfgSrcWidth  = 2'd0;
  localparam cfg_idx_t CfgSrcHeight = 2'd1;
  localparam cfg_idx_t CfgDstWidth  = 2'd2;
  localparam cfg_idx_t CfgDstHeight = 2'd3;

  localparam int unsigned RegW = 13;
  localparam logic [RegW-1:0] RegReset = 13'd256;
  localparam logic [RegW-1:0] CntMax   = 13'd4096;

  // 22-bit signed fixed-point coefficients with 20 fractional bits
  localparam logic signed [21:0] CoefRv = 22'sd1475871;
  localparam logic signed [21:0] CoefGv = 22'sd751724;
  localparam logic signed [21:0] CoefGu = 22'sd362283;
  localparam logic signed [21:0] CoefBu = 22'sd1865417;
  localparam logic signed [30:0] RoundHalf = 31'sd524288;
  localparam logic [7:0] ChromaBias = 8'd128;

endpackage

`default_nettype wire

[src/uyvy_resize_to_rgb.sv]
// UYVY pixel store with nearest-neighbor lookup and YUV to RGB conversion.
//
// Load words write one UYVY pixel into the on-chip frame store at
// pos_y times the source width plus pos_x; convert words look up the pixel
// pair around a map coordinate and return one RGB word with row and frame
// markers. One word is in flight at a time: a load steps through the
// row-address multiply and the frame store write, a convert through the
// row-address multiply, the frame store read, the registered coefficient
// multiplies (skipped when out of range) and the output step, before the
// next word is accepted. The finished RGB word sits in an output register,
// so the next input word is accepted while it waits; a convert only stalls
// in its last step if that register is still held. The frame store has one
// write port and two read ports and needs no clearing: entries never loaded
// read back undefined.
`default_nettype none

module uyvy_resize_to_rgb
  import uyvy_pkg::*;
#(
  parameter int unsigned SRC_PIXELS = 65536
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  // configuration
  input  wire logic            cfg_valid_i,
  output logic                 cfg_ready_o,
  input  wire cfg_idx_t        cfg_index_i,
  input  wire logic [RegW-1:0] cfg_data_i,
  // input words
  input  wire logic            in_valid_i,
  output logic                 in_stall_o,
  input  wire logic            kind_i,
  input  wire logic [11:0]     pos_x_i,
  input  wire logic [11:0]     pos_y_i,
  input  wire logic [7:0]      chroma_byte_i,
  input  wire logic [7:0]      luma_byte_i,
  // result words
  output logic                 out_valid_o,
  input  wire logic            out_stall_i,
  output logic [7:0]           red_o,
  output logic [7:0]           green_o,
  output logic [7:0]           blue_o,
  output logic                 end_of_row_o,
  output logic                 end_of_frame_o,
  output logic                 out_of_range_o
);

  localparam int unsigned AW = (SRC_PIXELS > 1) ? $clog2(SRC_PIXELS) : 1;
  localparam logic [25:0] SrcPixels = 26'(SRC_PIXELS);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_ADR,
    S_PROD,
    S_SUM
  } state_e;

  function automatic logic [RegW-1:0] limit_of(logic [RegW-1:0] v);
    logic [RegW-1:0] r;
    if (v == '0) begin
      r = RegW'(1);
    end else if (v > CntMax) begin
      r = CntMax;
    end else begin
      r = v;
    end
    return r;
  endfunction

  function automatic logic [7:0] to_byte(logic signed [30:0] s);
    logic [7:0] r;
    if (s[30]) begin
      r = 8'd0;
    end else if (|s[29:28]) begin
      r = 8'd255;
    end else begin
      r = s[27:20];
    end
    return r;
  endfunction

  state_e state_q;

  logic [RegW-1:0] src_w_q, src_h_q, dst_w_q, dst_h_q;
  logic [11:0]     col_q, row_q;

  logic        kind_q;
  logic [11:0] x_q, y_q;
  logic [15:0] pix_q;
  logic [24:0] prod_q;
  logic        oor_q;

  logic signed [30:0] base_q, p_rv_q, p_gv_q, p_gu_q, p_bu_q;

  logic [15:0] mem [SRC_PIXELS];
  logic [15:0] rd_even_q, rd_odd_q;

  // address path
  logic [25:0] addr_x, addr_e, addr_o;
  logic        in_src, load_ok, conv_oor;
  logic        mem_we, mem_re;

  assign addr_x = {1'b0, prod_q} + 26'(x_q);
  assign addr_e = {1'b0, prod_q} + 26'({x_q[11:1], 1'b0});
  assign addr_o = {1'b0, prod_q} + 26'({x_q[11:1], 1'b1});
  assign in_src = ({1'b0, x_q} < src_w_q) && ({1'b0, y_q} < src_h_q);
  assign load_ok  = in_src && (addr_x < SrcPixels);
  assign conv_oor = !in_src || (addr_o >= SrcPixels);
  assign mem_we = (state_q == S_ADR) && !kind_q && load_ok;
  assign mem_re = (state_q == S_ADR) && kind_q && !conv_oor;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[addr_x[AW-1:0]] <= pix_q;
    end
    if (mem_re) begin
      rd_even_q <= mem[addr_e[AW-1:0]];
      rd_odd_q  <= mem[addr_o[AW-1:0]];
    end
  end

  // conversion operands
  logic [7:0]         lum;
  logic signed [8:0]  u_s, v_s;
  logic signed [30:0] sum_r, sum_g, sum_b;

  assign lum = x_q[0] ? rd_odd_q[7:0] : rd_even_q[7:0];
  assign u_s = $signed({1'b0, rd_even_q[15:8]}) - $signed({1'b0, ChromaBias});
  assign v_s = $signed({1'b0, rd_odd_q[15:8]}) - $signed({1'b0, ChromaBias});
  assign sum_r = base_q + p_rv_q;
  assign sum_g = base_q - p_gv_q - p_gu_q;
  assign sum_b = base_q + p_bu_q;

  // frame counters
  logic        last_col, last_row;
  logic        out_free;

  assign last_col = (13'(col_q) + 13'd1) >= limit_of(dst_w_q);
  assign last_row = (13'(row_q) + 13'd1) >= limit_of(dst_h_q);
  assign out_free = !out_valid_o || !out_stall_i;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      src_w_q        <= RegReset;
      src_h_q        <= RegReset;
      dst_w_q        <= RegReset;
      dst_h_q        <= RegReset;
      col_q          <= '0;
      row_q          <= '0;
      out_valid_o    <= 1'b0;
      red_o          <= '0;
      green_o        <= '0;
      blue_o         <= '0;
      end_of_row_o   <= 1'b0;
      end_of_frame_o <= 1'b0;
      out_of_range_o <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          CfgSrcWidth:  src_w_q <= cfg_data_i;
          CfgSrcHeight: src_h_q <= cfg_data_i;
          CfgDstWidth:  dst_w_q <= cfg_data_i;
          CfgDstHeight: dst_h_q <= cfg_data_i;
          default: ;
        endcase
      end

      if ((state_q == S_SUM) && out_free) begin
        out_valid_o <= 1'b1;
      end else if (out_valid_o && !out_stall_i) begin
        out_valid_o <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            kind_q  <= kind_i;
            x_q     <= pos_x_i;
            y_q     <= pos_y_i;
            pix_q   <= {chroma_byte_i, luma_byte_i};
            state_q <= S_MUL;
          end
        end
        S_MUL: begin
          prod_q  <= 25'(y_q) * 25'(src_w_q);
          state_q <= S_ADR;
        end
        S_ADR: begin
          oor_q <= conv_oor;
          if (!kind_q) begin
            state_q <= S_IDLE;
          end else if (conv_oor) begin
            state_q <= S_SUM;
          end else begin
            state_q <= S_PROD;
          end
        end
        S_PROD: begin
          base_q  <= $signed({3'b000, lum, 20'd0}) + RoundHalf;
          p_rv_q  <= 31'(CoefRv) * 31'(v_s);
          p_gv_q  <= 31'(CoefGv) * 31'(v_s);
          p_gu_q  <= 31'(CoefGu) * 31'(u_s);
          p_bu_q  <= 31'(CoefBu) * 31'(u_s);
          state_q <= S_SUM;
        end
        S_SUM: begin
          if (out_free) begin
            out_of_range_o <= oor_q;
            red_o          <= oor_q ? 8'd0 : to_byte(sum_r);
            green_o        <= oor_q ? 8'd0 : to_byte(sum_g);
            blue_o         <= oor_q ? 8'd0 : to_byte(sum_b);
            end_of_row_o   <= last_col;
            end_of_frame_o <= last_col && last_row;
            if (last_col) begin
              col_q <= '0;
              row_q <= last_row ? 12'd0 : row_q + 12'd1;
            end else begin
              col_q <= col_q + 12'd1;
            end
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  a_oor_black: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_of_range_o |-> red_o == 8'd0 && green_o == 8'd0 && blue_o == 8'd0)
    else $error("out of range word carries color");

  a_eof_eor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && end_of_frame_o |-> end_of_row_o)
    else $error("end of frame without end of row");

  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == S_SUM))
    else $error("result word not from final step");

  a_accept_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> state_q == S_MUL)
    else $error("accepted word did not start address step");

  a_mem_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_we && mem_re))
    else $error("store written and read together");

endmodule

`default_nettype wire

[tb/sv/uyvy_tb_pkg.sv]
// Testbench package: word kind codes shared by the stimulus and the checker.
package uyvy_tb_pkg;

  localparam bit KindLoad    = 1'b0;
  localparam bit KindConvert = 1'b1;

endpackage

[tb/sv/uyvy_rgb_check.sv]
// Checker: mirrors the frame store, predicts each RGB word and compares it with the output.
module uyvy_rgb_check
  import uyvy_pkg::*;
  import uyvy_tb_pkg::*;
#(
  parameter int unsigned SRC_PIXELS = 65536
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_valid_i,
  input  logic            cfg_ready_i,
  input  cfg_idx_t        cfg_index_i,
  input  logic [RegW-1:0] cfg_data_i,
  input  logic            in_valid_i,
  input  logic            in_stall_i,
  input  logic            kind_i,
  input  logic [11:0]     pos_x_i,
  input  logic [11:0]     pos_y_i,
  input  logic [7:0]      chroma_byte_i,
  input  logic [7:0]      luma_byte_i,
  input  logic            out_valid_i,
  input  logic            out_stall_i,
  input  logic [7:0]      red_i,
  input  logic [7:0]      green_i,
  input  logic [7:0]      blue_i,
  input  logic            end_of_row_i,
  input  logic            end_of_frame_i,
  input  logic            out_of_range_i,
  output int              fail_count_o,
  output int              pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [RegW-1:0] SizeAtReset = 13'd256;
  localparam longint KRv = 1475871;
  localparam longint KGv = 751724;
  localparam longint KGu = 362283;
  localparam longint KBu = 1865417;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       eor;
    logic       eof;
    logic       oor;
  } rgb_word_t;

  logic [15:0]     frame_store [SRC_PIXELS];
  logic [RegW-1:0] src_w, src_h, dst_w, dst_h;
  logic [11:0]     col, row;
  rgb_word_t       expected_pixels [$];
  int              mismatches = 0;

  function automatic int unsigned size_limit(logic [RegW-1:0] v);
    if (v == 0) return 1;
    if (v > 13'd4096) return 4096;
    return 32'(v);
  endfunction

  // floor by 2^20, then saturate
  function automatic logic [7:0] sat_byte(longint acc);
    longint q;
    q = acc >>> 20;
    if (q < 0) return 8'd0;
    if (q > 255) return 8'd255;
    return q[7:0];
  endfunction

  function automatic rgb_word_t convert_pixel(logic [11:0] x, logic [11:0] y);
    rgb_word_t w;
    longint base, lum, u, v, yterm;
    w = '0;
    base = longint'(y) * longint'(src_w);
    w.oor = ({1'b0, x} >= src_w) || ({1'b0, y} >= src_h) ||
            (base + longint'(x | 12'd1) >= longint'(SRC_PIXELS));
    if (!w.oor) begin
      lum = longint'(frame_store[base + longint'(x)][7:0]);
      u = longint'(frame_store[base + longint'(x & 12'hFFE)][15:8]) - 128;
      v = longint'(frame_store[base + longint'(x | 12'd1)][15:8]) - 128;
      yterm = (lum <<< 20) + 524288;
      w.red   = sat_byte(yterm + KRv * v);
      w.green = sat_byte(yterm - KGv * v - KGu * u);
      w.blue  = sat_byte(yterm + KBu * u);
    end
    if (int'(col) + 1 >= size_limit(dst_w)) begin
      w.eor = 1'b1;
      col = '0;
      if (int'(row) + 1 >= size_limit(dst_h)) begin
        w.eof = 1'b1;
        row = '0;
      end else begin
        row = row + 12'd1;
      end
    end else begin
      col = col + 12'd1;
    end
    return w;
  endfunction

  always @(posedge clk_i) begin
    rgb_word_t got, want;
    longint base;
    if (!rst_ni) begin
      src_w = SizeAtReset;
      src_h = SizeAtReset;
      dst_w = SizeAtReset;
      dst_h = SizeAtReset;
      col = '0;
      row = '0;
      expected_pixels.delete();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        got = {red_i, green_i, blue_i, end_of_row_i, end_of_frame_i, out_of_range_i};
        if (expected_pixels.size() == 0) begin
          if (mismatches < 10)
            $display("%0t: unexpected RGB word r=%0d g=%0d b=%0d eor=%0b eof=%0b oor=%0b",
                     $time, got.red, got.green, got.blue, got.eor, got.eof, got.oor);
          mismatches++;
        end else begin
          want = expected_pixels.pop_front();
          if (got !== want) begin
            if (mismatches < 10)
              $display("%0t: RGB word mismatch: expected r=%0d g=%0d b=%0d eor=%0b eof=%0b",
                       $time, want.red, want.green, want.blue, want.eor, want.eof,
                       " oor=%0b, got r=%0d g=%0d b=%0d eor=%0b eof=%0b oor=%0b",
                       want.oor, got.red, got.green, got.blue, got.eor, got.eof, got.oor);
            mismatches++;
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CfgSrcWidth:  src_w = cfg_data_i;
          CfgSrcHeight: src_h = cfg_data_i;
          CfgDstWidth:  dst_w = cfg_data_i;
          CfgDstHeight: dst_h = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        if (kind_i == KindConvert) begin
          expected_pixels.push_back(convert_pixel(pos_x_i, pos_y_i));
        end else begin
          base = longint'(pos_y_i) * longint'(src_w);
          if ({1'b0, pos_x_i} < src_w && {1'b0, pos_y_i} < src_h &&
              base + longint'(pos_x_i) < longint'(SRC_PIXELS))
            frame_store[base + longint'(pos_x_i)] = {chroma_byte_i, luma_byte_i};
        end
      end
    end
    pending_o = expected_pixels.size();
    fail_count_o = mismatches;
  end

endmodule

[tb/sv/tb_uyvy_resize_to_rgb.sv]
// Testbench top: clock, reset, load and convert stimulus, receiver stalls and verdict.
module tb_uyvy_resize_to_rgb;
  timeunit 1ns;
  timeprecision 1ps;

  import uyvy_pkg::*;
  import uyvy_tb_pkg::*;

  localparam int unsigned SrcPixels  = 65536;
  localparam int unsigned HoldCycles = 200;

  logic            clk = 1'b0;
  logic            rst_n = 1'b0;
  logic            cfg_valid = 1'b0;
  logic            cfg_ready;
  cfg_idx_t        cfg_index = CfgSrcWidth;
  logic [RegW-1:0] cfg_data = '0;
  logic            in_valid = 1'b0;
  logic            in_stall;
  logic            kind = KindLoad;
  logic [11:0]     pos_x = '0;
  logic [11:0]     pos_y = '0;
  logic [7:0]      chroma = '0;
  logic [7:0]      luma = '0;
  logic            out_valid;
  logic            out_stall = 1'b0;
  logic [7:0]      red, green, blue;
  logic            end_of_row, end_of_frame, out_of_range;
  int              fail_count;
  int              pending;

  int              send_idle_pct = 17;
  int              recv_idle_pct = 84;
  int              hold_req = 0;
  int              hold_seen = 0;
  int unsigned     hold_left = 0;

  int unsigned     sw = 256;
  int unsigned     sh = 256;
  int unsigned     win_w, win_h;
  bit              loaded [SrcPixels];

  uyvy_resize_to_rgb #(.SRC_PIXELS(SrcPixels)) dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .kind_i         (kind),
    .pos_x_i        (pos_x),
    .pos_y_i        (pos_y),
    .chroma_byte_i  (chroma),
    .luma_byte_i    (luma),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .red_o          (red),
    .green_o        (green),
    .blue_o         (blue),
    .end_of_row_o   (end_of_row),
    .end_of_frame_o (end_of_frame),
    .out_of_range_o (out_of_range)
  );

  uyvy_rgb_check #(.SRC_PIXELS(SrcPixels)) rgb_check (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_i    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_stall_i     (in_stall),
    .kind_i         (kind),
    .pos_x_i        (pos_x),
    .pos_y_i        (pos_y),
    .chroma_byte_i  (chroma),
    .luma_byte_i    (luma),
    .out_valid_i    (out_valid),
    .out_stall_i    (out_stall),
    .red_i          (red),
    .green_i        (green),
    .blue_i         (blue),
    .end_of_row_i   (end_of_row),
    .end_of_frame_i (end_of_frame),
    .out_of_range_i (out_of_range),
    .fail_count_o   (fail_count),
    .pending_o      (pending)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // receiver: random stalls, plus a long hold-off on request
  always @(negedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_req != hold_seen) begin
      out_stall <= 1'b1;
      hold_left <= HoldCycles;
      hold_seen <= hold_req;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  initial begin
    #2ms;
    $display("FAILURE");
    $finish;
  end

  task automatic send_word(bit k, logic [11:0] x, logic [11:0] y, logic [7:0] c,
                           logic [7:0] l);
    longint addr;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    kind <= k;
    pos_x <= x;
    pos_y <= y;
    chroma <= c;
    luma <= l;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    addr = longint'(y) * longint'(sw) + longint'(x);
    if (k == KindLoad && 32'(x) < sw && 32'(y) < sh && addr < longint'(SrcPixels))
      loaded[addr] = 1'b1;
  endtask

  // a convert is legal when it is out of range or reads only loaded pixels
  function automatic bit convert_ok(int unsigned x, int unsigned y);
    longint base;
    base = longint'(y) * longint'(sw);
    if (x >= sw || y >= sh || base + longint'(x | 1) >= longint'(SrcPixels))
      return 1'b1;
    return loaded[base + longint'(x)] && loaded[base + longint'(x & ~1)] &&
           loaded[base + longint'(x | 1)];
  endfunction

  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (12) @(negedge clk);
  endtask

  task automatic set_frame(logic [RegW-1:0] w, h, dw, dh);
    logic [RegW-1:0] vals [4];
    cfg_idx_t        regs [4];
    vals = '{w, h, dw, dh};
    regs = '{CfgSrcWidth, CfgSrcHeight, CfgDstWidth, CfgDstHeight};
    for (int i = 0; i < 4; i++) begin
      cfg_index <= regs[i];
      cfg_data <= vals[i];
      cfg_valid <= 1'b1;
      do @(posedge clk); while (!cfg_ready);
      @(negedge clk);
    end
    cfg_valid <= 1'b0;
    sw = 32'(w);
    sh = 32'(h);
  endtask

  task automatic run_phase(logic [RegW-1:0] w, h, dw, dh, int unsigned ww, wh, items,
                           bit hold);
    int unsigned x, y, pick;
    drain();
    set_frame(w, h, dw, dh);
    win_w = ww;
    win_h = wh;
    for (int r = 0; r < wh; r++)
      for (int q = 0; q < ww; q++)
        send_word(KindLoad, 12'(q), 12'(r), 8'($urandom), 8'($urandom));
    if (hold) hold_req <= hold_req + 1;
    repeat (items) begin
      pick = $urandom_range(99);
      if (pick < 12 && win_w != 0) begin
        send_word(KindLoad, 12'($urandom_range(win_w - 1)), 12'($urandom_range(win_h - 1)),
                  8'($urandom), 8'($urandom));
      end else if (pick < 17) begin
        send_word(KindLoad, 12'($urandom_range(4095)), 12'($urandom_range(4095)),
                  8'($urandom), 8'($urandom));
      end else begin
        do begin
          if (win_w != 0 && $urandom_range(99) < 80) begin
            x = $urandom_range(win_w - 1);
            y = $urandom_range(win_h - 1);
          end else begin
            x = $urandom_range(4095);
            y = $urandom_range(4095);
          end
        end while (!convert_ok(x, y));
        send_word(KindConvert, 12'(x), 12'(y), 8'($urandom), 8'($urandom));
      end
    end
  endtask

  initial begin
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset geometry: extremes of bytes and coordinates, clamping both ways
    send_word(KindLoad, 12'd0, 12'd0, 8'd0, 8'd0);
    send_word(KindLoad, 12'd1, 12'd0, 8'd255, 8'd255);
    send_word(KindLoad, 12'd2, 12'd0, 8'd255, 8'd0);
    send_word(KindLoad, 12'd3, 12'd0, 8'd0, 8'd255);
    send_word(KindLoad, 12'd4095, 12'd0, 8'hAA, 8'h55);
    send_word(KindLoad, 12'd0, 12'd4095, 8'h55, 8'hAA);
    send_word(KindLoad, 12'd254, 12'd255, 8'd128, 8'd16);
    send_word(KindLoad, 12'd255, 12'd255, 8'd128, 8'd235);
    send_word(KindConvert, 12'd0, 12'd0, 8'd0, 8'd0);
    send_word(KindConvert, 12'd1, 12'd0, 8'd255, 8'd255);
    send_word(KindConvert, 12'd2, 12'd0, 8'd0, 8'd255);
    send_word(KindConvert, 12'd3, 12'd0, 8'd255, 8'd0);
    send_word(KindConvert, 12'd254, 12'd255, 8'h0F, 8'hF0);
    send_word(KindConvert, 12'd255, 12'd255, 8'hF0, 8'h0F);
    send_word(KindConvert, 12'd4095, 12'd4095, 8'd255, 8'd255);
    send_word(KindConvert, 12'd4095, 12'd0, 8'd0, 8'd0);
    send_word(KindConvert, 12'd0, 12'd4095, 8'd0, 8'd0);
    send_word(KindConvert, 12'd256, 12'd0, 8'd0, 8'd0);

    run_phase(13'd8, 13'd4, 13'd8, 13'd4, 8, 4, 220, 1'b1);
    run_phase(13'd7, 13'd5, 13'd0, 13'd0, 7, 5, 180, 1'b0);

    send_idle_pct = 84;
    recv_idle_pct <= 17;
    run_phase(13'd2, 13'd1, 13'd8191, 13'd4096, 2, 1, 120, 1'b0);
    run_phase(13'd4096, 13'd16, 13'd3, 13'd2, 16, 4, 180, 1'b0);

    send_idle_pct = 0;
    recv_idle_pct <= 0;
    run_phase(13'd8191, 13'd8191, 13'd1, 13'd4096, 12, 2, 120, 1'b0);
    run_phase(13'd256, 13'd256, 13'd256, 13'd256, 8, 8, 180, 1'b1);
    run_phase(13'd0, 13'd0, 13'd2, 13'd2, 0, 0, 50, 1'b0);

    drain();
    if (fail_count == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
